@@ sv/smfa_pkg.sv @@
`timescale 1ns / 1ps
package smfa_pkg;

   localparam int EXPONENT_BITS_DEFAULT = 11;
   localparam int FUNC_W     = 2;
   localparam int MANT_W     = 15;
   localparam int RES_EXP_W  = 13;

   localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd2;

   localparam int SCALE     = 10000;
   localparam int NORM_LOW  = 5000;
   localparam int ALIGN_CAP = 48;
   localparam int CNT_W     = 6;
   localparam int ACC_W     = 64;

   // magnitude product and reciprocal of the scale for the truncating divide
   localparam int PROD_W      = 2 * MANT_W;
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 44;
   localparam logic [RECIP_W-1:0] RECIP = 31'd1759218605;
   localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic align_step;
      logic sum_step;
      logic norm_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_addsub;
      logic align_done;
      logic norm_done;
      logic out_free;
   } dp_status_type;

endpackage

@@ sv/smfa_req_if.sv @@
`timescale 1ns / 1ps
interface smfa_req_if #(
   parameter int EXPONENT_BITS = smfa_pkg::EXPONENT_BITS_DEFAULT
);
   import smfa_pkg::*;

   logic                            valid;
   logic                            ready;
   logic        [FUNC_W-1:0]        func;
   logic signed [MANT_W-1:0]        a_mantissa;
   logic signed [EXPONENT_BITS-1:0] a_exponent;
   logic signed [MANT_W-1:0]        b_mantissa;
   logic signed [EXPONENT_BITS-1:0] b_exponent;

   modport source (
      output valid, func, a_mantissa, a_exponent, b_mantissa, b_exponent,
      input  ready
   );

   modport sink (
      input  valid, func, a_mantissa, a_exponent, b_mantissa, b_exponent,
      output ready
   );

endinterface

@@ sv/smfa_rsp_if.sv @@
`timescale 1ns / 1ps
interface smfa_rsp_if;
   import smfa_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [MANT_W-1:0]    result_mantissa;
   logic signed [RES_EXP_W-1:0] result_exponent;

   modport source (
      output valid, result_mantissa, result_exponent,
      input  ready
   );

   modport sink (
      input  valid, result_mantissa, result_exponent,
      output ready
   );

endinterface

@@ sv/smfa_ctrl.sv @@
`timescale 1ns / 1ps
module smfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  smfa_pkg::dp_status_type status,
   output smfa_pkg::dp_cmd_type    cmd
);
   import smfa_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_MUL      = 3'd2;
   localparam logic [2:0] ST_ALIGN    = 3'd3;
   localparam logic [2:0] ST_SUM      = 3'd4;
   localparam logic [2:0] ST_NORM     = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (status.is_mul) begin
               state_in = ST_MUL;
            end else if (status.is_addsub) begin
               state_in = ST_ALIGN;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_NORM;
         end
         ST_ALIGN: begin
            if (status.align_done) begin
               state_in = ST_SUM;
            end else begin
               cmd.align_step = 1'b1;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            state_in     = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cmd_single: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_reset_idle: assert property (@(posedge clock) reset |=> state_ff == ST_IDLE)
      else $error("controller not idle after reset");

   a_load_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DISPATCH)
      else $error("request taken without dispatch");

endmodule

@@ sv/smfa_dp.sv @@
`timescale 1ns / 1ps
module smfa_dp #(
   parameter int EXPONENT_BITS = smfa_pkg::EXPONENT_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  smfa_pkg::dp_cmd_type                    cmd,
   output smfa_pkg::dp_status_type                 status,
   input  logic        [smfa_pkg::FUNC_W-1:0]      req_func,
   input  logic signed [smfa_pkg::MANT_W-1:0]      req_a_mantissa,
   input  logic signed [EXPONENT_BITS-1:0]         req_a_exponent,
   input  logic signed [smfa_pkg::MANT_W-1:0]      req_b_mantissa,
   input  logic signed [EXPONENT_BITS-1:0]         req_b_exponent,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [smfa_pkg::MANT_W-1:0]      rsp_result_mantissa,
   output logic signed [smfa_pkg::RES_EXP_W-1:0]   rsp_result_exponent
);
   import smfa_pkg::*;

   localparam int EB = EXPONENT_BITS;
   localparam int EW = (EB + 3 > RES_EXP_W + 1) ? EB + 3 : RES_EXP_W + 1;
   localparam int OW = MANT_W + 1;
   localparam logic signed [EW-1:0] EXP_MAX = EW'((2 ** (RES_EXP_W - 1)) - 1);
   localparam logic signed [EW-1:0] EXP_MIN = EW'(-(2 ** (RES_EXP_W - 1)));

   // operand decode on the request
   logic signed [OW-1:0] ma_w;
   logic signed [OW-1:0] mb_raw;
   logic signed [OW-1:0] mb_w;
   logic signed [EB:0]   ea_x;
   logic signed [EB:0]   eb_x;
   logic signed [EB:0]   diff_s;
   logic                 a_ge;
   logic        [EB:0]   gap;
   logic signed [OW-1:0] big;
   logic signed [OW-1:0] lesser;
   logic signed [EB-1:0] emin;
   logic                 big_zero;
   logic                 far;
   logic        [EB:0]   extra;
   logic signed [OW-1:0] small_sign;
   logic        [MANT_W-1:0] mag_a;
   logic        [MANT_W-1:0] mag_b;
   logic signed [EW-1:0] exp_mul;
   logic signed [EW-1:0] exp_add;

   logic        [FUNC_W-1:0] func_ff;
   logic        [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [OW-1:0]     addend_ff;
   logic        [CNT_W-1:0]  count_ff;
   logic        [ACC_W-1:0]  mag_ff;
   logic        [ACC_W-1:0]  mag_in;
   logic signed [EW-1:0]     exp_ff;
   logic signed [EW-1:0]     exp_in;
   logic                     neg_ff;
   logic                     neg_in;
   logic                     zero_ff;
   logic                     zero_in;

   logic [PROD_W+RECIP_W-1:0] recip_prod;
   logic [QUOT_W-1:0]         quot;
   logic signed [ACC_W-1:0]   sum;
   logic signed [EW-1:0]      exp_sat;
   logic [MANT_W-1:0]         mant_mag;

   logic                        out_valid_ff;
   logic signed [MANT_W-1:0]    res_mant_ff;
   logic signed [RES_EXP_W-1:0] res_exp_ff;

   always_comb begin
      ma_w       = {req_a_mantissa[MANT_W-1], req_a_mantissa};
      mb_raw     = {req_b_mantissa[MANT_W-1], req_b_mantissa};
      mb_w       = (req_func == FUNC_SUB) ? -mb_raw : mb_raw;
      ea_x       = {req_a_exponent[EB-1], req_a_exponent};
      eb_x       = {req_b_exponent[EB-1], req_b_exponent};
      a_ge       = (req_a_exponent >= req_b_exponent);
      diff_s     = ea_x - eb_x;
      gap        = a_ge ? diff_s : -diff_s;
      big        = a_ge ? ma_w : mb_w;
      lesser     = a_ge ? mb_w : ma_w;
      emin       = a_ge ? req_b_exponent : req_a_exponent;
      big_zero   = (big == '0);
      far        = !big_zero && (gap > (EB + 1)'(ALIGN_CAP));
      extra      = far ? gap - (EB + 1)'(ALIGN_CAP) : '0;
      small_sign = (lesser == '0) ? '0 : (lesser[OW-1] ? '1 : OW'(1));
      mag_a      = ma_w[OW-1] ? MANT_W'(-ma_w) : ma_w[MANT_W-1:0];
      mag_b      = mb_w[OW-1] ? MANT_W'(-mb_w) : mb_w[MANT_W-1:0];
      exp_mul    = $signed({{(EW - EB){req_a_exponent[EB-1]}}, req_a_exponent})
                 + $signed({{(EW - EB){req_b_exponent[EB-1]}}, req_b_exponent});
      exp_add    = $signed({{(EW - EB){emin[EB-1]}}, emin})
                 + $signed({{(EW - EB - 1){1'b0}}, extra});
   end

   always_comb begin
      recip_prod = prod_ff * RECIP;
      quot       = recip_prod[RECIP_SHIFT +: QUOT_W];
      sum        = acc_ff + {{(ACC_W - OW){addend_ff[OW-1]}}, addend_ff};
   end

   always_comb begin
      acc_in  = acc_ff;
      mag_in  = mag_ff;
      exp_in  = exp_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      priority if (cmd.load) begin
         acc_in  = big_zero ? '0 : {{(ACC_W - OW){big[OW-1]}}, big};
         exp_in  = (req_func == FUNC_MUL) ? exp_mul : exp_add;
         neg_in  = ma_w[OW-1] ^ mb_w[OW-1];
         zero_in = (req_func != FUNC_ADD) && (req_func != FUNC_SUB)
                 && (req_func != FUNC_MUL);
      end else if (cmd.mul_step) begin
         mag_in  = ACC_W'(quot);
         zero_in = (quot == '0);
      end else if (cmd.align_step) begin
         acc_in  = acc_ff <<< 1;
      end else if (cmd.sum_step) begin
         neg_in  = sum[ACC_W-1];
         mag_in  = sum[ACC_W-1] ? -sum : sum;
         zero_in = (sum == '0);
      end else if (cmd.norm_step) begin
         if (mag_ff >= ACC_W'(SCALE)) begin
            mag_in = mag_ff >> 1;
            exp_in = exp_ff + EW'(1);
         end else begin
            mag_in = mag_ff << 1;
            exp_in = exp_ff - EW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      exp_ff  <= exp_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      if (cmd.load) begin
         func_ff   <= req_func;
         prod_ff   <= mag_a * mag_b;
         addend_ff <= far ? small_sign : lesser;
         count_ff  <= big_zero ? '0 : (far ? CNT_W'(ALIGN_CAP) : gap[CNT_W-1:0]);
      end else if (cmd.align_step) begin
         count_ff  <= count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      status.is_mul     = (func_ff == FUNC_MUL);
      status.is_addsub  = (func_ff == FUNC_ADD) || (func_ff == FUNC_SUB);
      status.align_done = (count_ff == '0);
      status.norm_done  = zero_ff
                        || ((mag_ff >= ACC_W'(NORM_LOW)) && (mag_ff < ACC_W'(SCALE)));
      status.out_free   = !out_valid_ff || rsp_ready;
   end

   // output register with exponent saturation
   always_comb begin
      priority if (exp_ff > EXP_MAX) begin
         exp_sat = EXP_MAX;
      end else if (exp_ff < EXP_MIN) begin
         exp_sat = EXP_MIN;
      end else begin
         exp_sat = exp_ff;
      end
      mant_mag = mag_ff[MANT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (zero_ff) begin
            res_mant_ff <= '0;
            res_exp_ff  <= '0;
         end else begin
            res_mant_ff <= neg_ff ? -$signed(mant_mag) : $signed(mant_mag);
            res_exp_ff  <= exp_sat[RES_EXP_W-1:0];
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_mantissa = res_mant_ff;
   assign rsp_result_exponent = res_exp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   a_align_count: assert property (@(posedge clock) disable iff (reset)
      cmd.align_step |-> (count_ff != '0))
      else $error("alignment count wrapped");

   a_zero_exp: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (res_mant_ff == '0)) |-> (res_exp_ff == '0))
      else $error("zero result with nonzero exponent");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (res_mant_ff != '0)) |->
         ((res_mant_ff >= 15'sd5000 && res_mant_ff <= 15'sd9999)
          || (res_mant_ff <= -15'sd5000 && res_mant_ff >= -15'sd9999)))
      else $error("result mantissa not normalised");

endmodule

@@ sv/scaled_mantissa_float_alu.sv @@
`timescale 1ns / 1ps
// channel   modport  handshake      payload
// req_bus   sink     valid/ready    func, a_mantissa, a_exponent, b_mantissa, b_exponent
// rsp_bus   source   valid/ready    result_mantissa, result_exponent
//
// multiply: load, dispatch, multiply, n normalisation shifts, finish; unused code: load,
// dispatch, zero check, finish; add/subtract: load, dispatch, c alignment shifts, sum, n
// normalisation shifts, finish, where c is the exponent gap capped at 48 (0 when the
// larger-exponent operand is zero); normalisation and alignment shift one bit per cycle
// reset clears the controller state and the result valid flag only
// the result register lets the next request in while a result waits; a stalled
// result holds the finish step of the following request
module scaled_mantissa_float_alu #(
   parameter int EXPONENT_BITS = smfa_pkg::EXPONENT_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   smfa_req_if.sink   req_bus,
   smfa_rsp_if.source rsp_bus
);
   import smfa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   smfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smfa_dp #(
      .EXPONENT_BITS (EXPONENT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_bus.func),
      .req_a_mantissa      (req_bus.a_mantissa),
      .req_a_exponent      (req_bus.a_exponent),
      .req_b_mantissa      (req_bus.b_mantissa),
      .req_b_exponent      (req_bus.b_exponent),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_result_mantissa (rsp_bus.result_mantissa),
      .rsp_result_exponent (rsp_bus.result_exponent)
   );

endmodule
